>>> src/hest_pkg.sv
// Shared types and constants for the hidden entry set difference tracker.
`timescale 1ns / 1ps
`default_nettype none
package hest_pkg;

  localparam int unsigned IdW = 22;

  localparam logic [1:0] OP_LOAD_FULL = 2'd0;
  localparam logic [1:0] OP_LOAD_VIS  = 2'd1;
  localparam logic [1:0] OP_COMPARE   = 2'd2;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_CONFIRM = 2'd1;
  localparam logic [1:0] KIND_EXIT    = 2'd2;

  localparam logic [1:0] SEEN_ONCE  = 2'd1;
  localparam logic [1:0] SEEN_TWICE = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_full;
    logic load_vis;
    logic done_now;
    logic cmp_start;
    logic i_inc;
    logic j_inc;
    logic k_clr;
    logic k_inc;
    logic add_new;
    logic set_drop;
    logic mark_hit;
    logic push_conf;
    logic cp_keep;
    logic push_exit;
    logic cp_finish;
    logic push_done;
    logic emit;
    logic end_period;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic eq_len;
    logic i_end;
    logic j_ok;
    logic v_lt;
    logic v_eq;
    logic k_end;
    logic tbl_full;
    logic hit;
    logic marked;
    logic seen_one;
    logic r_last;
  } sts_t;

endpackage
`default_nettype wire

>>> src/hidden_entry_set_difference_tracker_top.sv
// Top level of the hidden entry set difference tracker.
`timescale 1ns / 1ps
`default_nettype none
// Load transactions (opcode 0 full list, 1 visible list) append the id if
// that list is not full; busy_o stays low, so one may be issued every cycle.
// A compare transaction (opcode 2) with equal list lengths returns only the
// done marker. Otherwise busy_o rises and the controller walks both lists
// with a fetch and a compare state per step (registered memory reads),
// searches the tracking table with a read and a check state per entry for
// each missing id, compacts the table likewise, and then drains the
// buffered results with a wait and an output state each. Results are held
// until the end so that every one carries the final table_full flag. Each
// result is shown for one cycle on result_valid_o; the receiver cannot
// stall, so take it in that cycle. Opcode 3 is accepted and ignored.
module hidden_entry_set_difference_tracker_top #(
  parameter int unsigned LIST_DEPTH  = 1024,
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [1:0]               opcode_i,
  input  wire logic [hest_pkg::IdW-1:0] pid_i,
  output logic                          result_valid_o,
  output logic [1:0]                    kind_o,
  output logic [hest_pkg::IdW-1:0]      report_id_o,
  output logic                          table_full_o,
  output logic                          last_o
);

  hest_pkg::cmd_t cmd;
  hest_pkg::sts_t sts;

  // Sequence each transaction.
  hest_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Hold lists, table and results.
  hest_dp #(
    .LIST_DEPTH  (LIST_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .pid_i          (pid_i),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .report_id_o    (report_id_o),
    .table_full_o   (table_full_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

>>> src/hest_ctrl.sv
// Controller state machine sequencing merge, table search, compaction and drain.
`timescale 1ns / 1ps
`default_nettype none
module hest_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [1:0]    opcode_i,
  input  wire hest_pkg::sts_t sts_i,
  output hest_pkg::cmd_t     cmd_o,
  output logic               busy_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FETCH = 9'b000000010,
    ST_CMP   = 9'b000000100,
    ST_SRD   = 9'b000001000,
    ST_SCHK  = 9'b000010000,
    ST_CRD   = 9'b000100000,
    ST_CCHK  = 9'b001000000,
    ST_DWAIT = 9'b010000000,
    ST_DOUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_full = accept && (opcode_i == hest_pkg::OP_LOAD_FULL);
        cmd_o.load_vis  = accept && (opcode_i == hest_pkg::OP_LOAD_VIS);
        if (accept && (opcode_i == hest_pkg::OP_COMPARE)) begin
          if (sts_i.eq_len) begin
            cmd_o.done_now = 1'b1;
          end else begin
            cmd_o.cmp_start = 1'b1;
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (sts_i.i_end) begin
          cmd_o.k_clr = 1'b1;
          state_d = ST_CRD;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts_i.j_ok && sts_i.v_lt) begin
          cmd_o.j_inc = 1'b1;
          state_d = ST_FETCH;
        end else if (sts_i.j_ok && sts_i.v_eq) begin
          cmd_o.i_inc = 1'b1;
          cmd_o.j_inc = 1'b1;
          state_d = ST_FETCH;
        end else begin
          cmd_o.k_clr = 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        if (sts_i.k_end) begin
          cmd_o.set_drop = sts_i.tbl_full;
          cmd_o.add_new  = !sts_i.tbl_full;
          cmd_o.i_inc    = 1'b1;
          state_d = ST_FETCH;
        end else begin
          state_d = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (sts_i.hit) begin
          cmd_o.mark_hit  = !sts_i.marked;
          cmd_o.push_conf = !sts_i.marked && sts_i.seen_one;
          cmd_o.i_inc     = 1'b1;
          state_d = ST_FETCH;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_CRD: begin
        if (sts_i.k_end) begin
          cmd_o.cp_finish = 1'b1;
          cmd_o.push_done = 1'b1;
          state_d = ST_DWAIT;
        end else begin
          state_d = ST_CCHK;
        end
      end
      ST_CCHK: begin
        cmd_o.cp_keep   = sts_i.marked;
        cmd_o.push_exit = !sts_i.marked;
        cmd_o.k_inc     = 1'b1;
        state_d = ST_CRD;
      end
      ST_DWAIT: begin
        state_d = ST_DOUT;
      end
      ST_DOUT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.r_last) begin
          cmd_o.end_period = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DWAIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> src/hest_dp.sv
// Datapath: list memories, tracking table, result buffer and output registers.
`timescale 1ns / 1ps
`default_nettype none
module hest_dp #(
  parameter int unsigned LIST_DEPTH  = 1024,
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hest_pkg::cmd_t            cmd_i,
  input  wire logic [hest_pkg::IdW-1:0]  pid_i,
  output hest_pkg::sts_t                 sts_o,
  output logic                           result_valid_o,
  output logic [1:0]                     kind_o,
  output logic [hest_pkg::IdW-1:0]       report_id_o,
  output logic                           table_full_o,
  output logic                           last_o
);

  localparam int unsigned IW  = hest_pkg::IdW;
  localparam int unsigned EW  = IW + 2;
  localparam int unsigned LW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW  = $clog2(LIST_DEPTH);
  localparam int unsigned TW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RD  = TABLE_DEPTH + 1;
  localparam int unsigned RAW = $clog2(RD);
  localparam int unsigned RCW = $clog2(RD + 1);

  logic [IW-1:0] full_mem [LIST_DEPTH];
  logic [IW-1:0] vis_mem  [LIST_DEPTH];
  logic [EW-1:0] tbl_mem  [TABLE_DEPTH];
  logic [EW-1:0] res_mem  [RD];

  logic [LW-1:0]          flen_q, vlen_q, i_q, j_q;
  logic [IW-1:0]          f_q, v_q;
  logic [TW-1:0]          tlen_q, k_q, w_q;
  logic [TABLE_DEPTH-1:0] present_q;
  logic [EW-1:0]          t_q, r_q;
  logic                   drop_q;
  logic [RCW-1:0]         wcnt_q, rcnt_q;
  logic                   push;
  logic [EW-1:0]          push_data;

  logic                   valid_q, full_q, last_q;
  logic [1:0]             kind_q;
  logic [IW-1:0]          id_q;

  assign sts_o.eq_len   = (flen_q == vlen_q);
  assign sts_o.i_end    = (i_q == flen_q);
  assign sts_o.j_ok     = (j_q < vlen_q);
  assign sts_o.v_lt     = (v_q < f_q);
  assign sts_o.v_eq     = (v_q == f_q);
  assign sts_o.k_end    = (k_q == tlen_q);
  assign sts_o.tbl_full = (tlen_q == TW'(TABLE_DEPTH));
  assign sts_o.hit      = (t_q[IW-1:0] == f_q);
  assign sts_o.marked   = present_q[k_q[TAW-1:0]];
  assign sts_o.seen_one = (t_q[EW-1:IW] == hest_pkg::SEEN_ONCE);
  assign sts_o.r_last   = (RCW'(rcnt_q + 1'b1) == wcnt_q);

  assign push = cmd_i.push_conf || cmd_i.push_exit || cmd_i.push_done;
  always_comb begin
    push_data = {hest_pkg::KIND_DONE, {IW{1'b0}}};
    if (cmd_i.push_conf) begin
      push_data = {hest_pkg::KIND_CONFIRM, f_q};
    end else if (cmd_i.push_exit) begin
      push_data = {hest_pkg::KIND_EXIT, t_q[IW-1:0]};
    end
  end

  // List memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_full && (flen_q < LW'(LIST_DEPTH))) begin
      full_mem[flen_q[AW-1:0]] <= pid_i;
    end
    if (cmd_i.load_vis && (vlen_q < LW'(LIST_DEPTH))) begin
      vis_mem[vlen_q[AW-1:0]] <= pid_i;
    end
    f_q <= full_mem[i_q[AW-1:0]];
    v_q <= vis_mem[j_q[AW-1:0]];
  end

  // Tracking table: seen count and id per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_new) begin
      tbl_mem[tlen_q[TAW-1:0]] <= {hest_pkg::SEEN_ONCE, f_q};
    end else if (cmd_i.push_conf) begin
      tbl_mem[k_q[TAW-1:0]] <= {hest_pkg::SEEN_TWICE, f_q};
    end else if (cmd_i.cp_keep) begin
      tbl_mem[w_q[TAW-1:0]] <= t_q;
    end
    t_q <= tbl_mem[k_q[TAW-1:0]];
  end

  // Result buffer.
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_mem[wcnt_q[RAW-1:0]] <= push_data;
    end
    r_q <= res_mem[rcnt_q[RAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q    <= '0;
      vlen_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      tlen_q    <= '0;
      k_q       <= '0;
      w_q       <= '0;
      present_q <= '0;
      drop_q    <= 1'b0;
      wcnt_q    <= '0;
      rcnt_q    <= '0;
      valid_q   <= 1'b0;
      kind_q    <= hest_pkg::KIND_DONE;
      id_q      <= '0;
      full_q    <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.done_now || cmd_i.emit;
      if (cmd_i.load_full && (flen_q < LW'(LIST_DEPTH))) flen_q <= flen_q + 1'b1;
      if (cmd_i.load_vis && (vlen_q < LW'(LIST_DEPTH))) vlen_q <= vlen_q + 1'b1;
      if (cmd_i.done_now || cmd_i.end_period) begin
        flen_q <= '0;
        vlen_q <= '0;
      end
      if (cmd_i.cmp_start) begin
        i_q       <= '0;
        j_q       <= '0;
        present_q <= '0;
        drop_q    <= 1'b0;
        wcnt_q    <= '0;
        rcnt_q    <= '0;
      end
      if (cmd_i.i_inc) i_q <= i_q + 1'b1;
      if (cmd_i.j_inc) j_q <= j_q + 1'b1;
      if (cmd_i.k_clr) begin
        k_q <= '0;
        w_q <= '0;
      end
      if (cmd_i.k_inc) k_q <= k_q + 1'b1;
      if (cmd_i.set_drop) drop_q <= 1'b1;
      if (cmd_i.add_new) begin
        present_q[tlen_q[TAW-1:0]] <= 1'b1;
        tlen_q <= tlen_q + 1'b1;
      end
      if (cmd_i.mark_hit) present_q[k_q[TAW-1:0]] <= 1'b1;
      if (cmd_i.cp_keep) begin
        present_q[w_q[TAW-1:0]] <= 1'b1;
        w_q <= w_q + 1'b1;
      end
      if (cmd_i.cp_finish) begin
        // drop marks beyond the compacted end
        for (int x = 0; x < TABLE_DEPTH; x++) begin
          if (TW'(x) >= w_q) present_q[x] <= 1'b0;
        end
        tlen_q <= w_q;
      end
      if (push) wcnt_q <= wcnt_q + 1'b1;
      if (cmd_i.emit) begin
        rcnt_q <= rcnt_q + 1'b1;
        kind_q <= r_q[EW-1:IW];
        id_q   <= r_q[IW-1:0];
        full_q <= drop_q;
        last_q <= sts_o.r_last;
      end
      if (cmd_i.done_now) begin
        kind_q <= hest_pkg::KIND_DONE;
        id_q   <= '0;
        full_q <= 1'b0;
        last_q <= 1'b1;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign kind_o         = kind_q;
  assign report_id_o    = id_q;
  assign table_full_o   = full_q;
  assign last_o         = last_q;

  a_tlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= TW'(TABLE_DEPTH)) else $error("table length overflow");
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= RCW'(RD)) else $error("result buffer overflow");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> kind_q == hest_pkg::KIND_DONE) else $error("last not on done");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && r_q[EW-1:IW] == hest_pkg::KIND_DONE |-> sts_o.r_last)
    else $error("done marker not final");

endmodule
`default_nettype wire

>>> tb/sv/tb_hidden_entry_set_difference_tracker_top.sv
// Testbench for the hidden entry set difference tracker: queued driver, predictor, checker.
`timescale 1ns / 1ps
module tb_hidden_entry_set_difference_tracker_top;

  localparam int unsigned IdW         = hest_pkg::IdW;
  localparam int unsigned LIST_DEPTH  = 1024;
  localparam int unsigned TABLE_DEPTH = 32;
  localparam longint     CYCLE_LIMIT = 64'd3000000;
  // Opcode with no defined meaning; the block must ignore it.
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]     opcode;
    logic [IdW-1:0] pid;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] report_id;
    logic           table_full;
    logic           last;
  } report_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  logic [1:0]     opcode_i;
  logic [IdW-1:0] pid_i;
  logic           result_valid_o;
  logic [1:0]     kind_o;
  logic [IdW-1:0] report_id_o;
  logic           table_full_o;
  logic           last_o;

  hidden_entry_set_difference_tracker_top #(
    .LIST_DEPTH (LIST_DEPTH),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .pid_i,
    .result_valid_o, .kind_o, .report_id_o, .table_full_o, .last_o
  );

  // Predictor state: a private copy of the lists and the tracking table.
  logic [IdW-1:0] full_ids[LIST_DEPTH];
  logic [IdW-1:0] vis_ids[LIST_DEPTH];
  int unsigned    full_cnt, vis_cnt;
  logic [IdW-1:0] trk_id[TABLE_DEPTH];
  logic [1:0]     trk_seen[TABLE_DEPTH];
  logic           trk_mark[TABLE_DEPTH];
  int unsigned    trk_cnt;

  cmd_item_t pending_q[$];
  report_t   expected_q[$];
  int        errors;
  longint    cycles;
  bit        stim_done;

  // Work out the reports that one accepted transaction should produce.
  task automatic predict_reports(input cmd_item_t it);
    report_t     outs[$];
    report_t     r;
    logic [IdW-1:0] f;
    int unsigned i, j, k, w;
    bit          dropped;
    dropped = 0;
    if (it.opcode == hest_pkg::OP_LOAD_FULL) begin
      if (full_cnt < LIST_DEPTH) begin
        full_ids[full_cnt] = it.pid;
        full_cnt++;
      end
      return;
    end
    if (it.opcode == hest_pkg::OP_LOAD_VIS) begin
      if (vis_cnt < LIST_DEPTH) begin
        vis_ids[vis_cnt] = it.pid;
        vis_cnt++;
      end
      return;
    end
    if (it.opcode != hest_pkg::OP_COMPARE) return;
    if (full_cnt != vis_cnt) begin
      for (k = 0; k < trk_cnt; k++) trk_mark[k] = 0;
      i = 0;
      j = 0;
      while (i < full_cnt) begin
        f = full_ids[i];
        while (j < vis_cnt && vis_ids[j] < f) j++;
        if (j < vis_cnt && vis_ids[j] == f) begin
          i++;
          j++;
          continue;
        end
        for (k = 0; k < trk_cnt; k++) if (trk_id[k] == f) break;
        if (k < trk_cnt) begin
          if (!trk_mark[k]) begin
            trk_mark[k] = 1;
            if (trk_seen[k] == hest_pkg::SEEN_ONCE) begin
              trk_seen[k] = hest_pkg::SEEN_TWICE;
              r = '{hest_pkg::KIND_CONFIRM, f, 1'b0, 1'b0};
              outs.push_back(r);
            end
          end
        end else if (trk_cnt < TABLE_DEPTH) begin
          trk_id[trk_cnt]   = f;
          trk_seen[trk_cnt] = hest_pkg::SEEN_ONCE;
          trk_mark[trk_cnt] = 1;
          trk_cnt++;
        end else begin
          dropped = 1;
        end
        i++;
      end
      // Report unmarked entries as exited and compact the survivors.
      w = 0;
      for (k = 0; k < trk_cnt; k++) begin
        if (!trk_mark[k]) begin
          r = '{hest_pkg::KIND_EXIT, trk_id[k], 1'b0, 1'b0};
          outs.push_back(r);
        end else begin
          trk_id[w]   = trk_id[k];
          trk_seen[w] = trk_seen[k];
          trk_mark[w] = 1;
          w++;
        end
      end
      for (k = w; k < trk_cnt; k++) trk_mark[k] = 0;
      trk_cnt = w;
    end
    r = '{hest_pkg::KIND_DONE, '0, 1'b0, 1'b1};
    outs.push_back(r);
    foreach (outs[n]) begin
      outs[n].table_full = dropped;
      expected_q.push_back(outs[n]);
    end
    full_cnt = 0;
    vis_cnt  = 0;
  endtask

  task automatic add_item(input logic [1:0] op, input logic [IdW-1:0] id);
    cmd_item_t it;
    it.opcode = op;
    it.pid    = id;
    pending_q.push_back(it);
  endtask

  // Queue a well-formed period: a sorted full list, a visible list that
  // drops each id with a chance of hide_pct percent, then a compare. Ids come
  // from a small pool so that hidden ids recur across periods.
  task automatic add_period(input int unsigned n, input int unsigned base,
                            input int unsigned hide_pct);
    logic [IdW-1:0] ids[$];
    int unsigned    v;
    v = base;
    for (int unsigned m = 0; m < n; m++) begin
      v += $urandom_range(1, 3);
      ids.push_back(v[IdW-1:0]);
    end
    foreach (ids[m]) add_item(hest_pkg::OP_LOAD_FULL, ids[m]);
    foreach (ids[m]) begin
      if ($urandom_range(99) >= hide_pct) add_item(hest_pkg::OP_LOAD_VIS, ids[m]);
    end
    add_item(hest_pkg::OP_COMPARE, IdW'($urandom));
  endtask

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Fill the stimulus queue: directed cases first, then random transactions and periods.
  initial begin
    errors = 0;
    full_cnt = 0;
    vis_cnt  = 0;
    trk_cnt  = 0;
    stim_done = 0;
    for (int k = 0; k < TABLE_DEPTH; k++) trk_mark[k] = 0;
    // Equal lengths: only the done marker.
    add_item(hest_pkg::OP_COMPARE, '1);
    add_item(hest_pkg::OP_LOAD_FULL, '1);
    add_item(hest_pkg::OP_LOAD_VIS, '0);
    add_item(hest_pkg::OP_COMPARE, '0);
    // Extreme ids hidden; unknown opcode ignored.
    add_item(hest_pkg::OP_LOAD_FULL, '0);
    add_item(hest_pkg::OP_LOAD_FULL, 22'h2AAAAA);
    add_item(hest_pkg::OP_LOAD_FULL, '1);
    add_item(OP_UNUSED, 22'h155555);
    add_item(hest_pkg::OP_LOAD_VIS, 22'h2AAAAA);
    add_item(hest_pkg::OP_COMPARE, '0);
    // Same ids hidden again: confirmed; a duplicate and a tail id counted.
    add_item(hest_pkg::OP_LOAD_FULL, '0);
    add_item(hest_pkg::OP_LOAD_FULL, '0);
    add_item(hest_pkg::OP_LOAD_FULL, '1);
    add_item(hest_pkg::OP_LOAD_VIS, 22'h000005);
    add_item(hest_pkg::OP_COMPARE, '0);
    // Neither present: both exit.
    add_item(hest_pkg::OP_LOAD_FULL, 22'h000010);
    add_item(hest_pkg::OP_COMPARE, '0);
    // Overflow the table with hidden ids in one period, dropping the excess, then again.
    add_period(40, 100, 100);
    add_period(40, 100, 100);
    while (pending_q.size() < 140) begin
      case ($urandom_range(9))
        0: begin
          add_item(2'($urandom_range(3)), IdW'($urandom));
        end
        1: begin
          add_item(hest_pkg::OP_LOAD_FULL, IdW'($urandom));
          add_item(hest_pkg::OP_LOAD_VIS, IdW'($urandom));
          add_item(hest_pkg::OP_COMPARE, IdW'($urandom));
        end
        default: begin
          add_period($urandom_range(1, 12), $urandom_range(0, 40), $urandom_range(5, 50));
        end
      endcase
    end
    // Upper id bits: a period well up in the id range.
    add_period(6, 22'h3FFF00, 50);
    stim_done = 1;
  end

  // Driver: bursts of back-to-back transactions separated by random gaps.
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 0;
      opcode_i   <= '0;
      pid_i      <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!start_i || !busy_o) begin
      // Previous transaction (if any) has been taken at this edge.
      if (start_i) predict_reports('{opcode_i, pid_i});
      if (gap_left != 0) begin
        start_i  <= 0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        cmd_item_t it;
        it = pending_q.pop_front();
        start_i  <= 1;
        opcode_i <= it.opcode;
        pid_i    <= it.pid;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 0;
      end
    end
  end

  // Monitor: compare every strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      report_t got, exp_r;
      got = '{kind_o, report_id_o, table_full_o, last_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind != exp_r.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
          errors++;
        end
        if (got.report_id != exp_r.report_id) begin
          $display("%0t: report_id expected %h actual %h", $time, exp_r.report_id,
                   got.report_id);
          errors++;
        end
        if (got.table_full != exp_r.table_full) begin
          $display("%0t: table_full expected %0b actual %0b", $time, exp_r.table_full,
                   got.table_full);
          errors++;
        end
        if (got.last != exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last, got.last);
          errors++;
        end
      end
    end
  end

  // End of run: drain, allow a tail for late results, or time out.
  initial begin
    cycles = 0;
    fork
      begin
        wait (stim_done);
        while (pending_q.size() != 0 || start_i || expected_q.size() != 0)
          @(posedge clk_i);
        repeat (500) @(posedge clk_i);
        if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
      end
      begin
        while (cycles < CYCLE_LIMIT) begin
          @(posedge clk_i);
          cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    join
  end

endmodule
